### sv/gdrf_pkg.sv
// gdrf_pkg: widths, fixed-point constants, cell data types and the cordic tables
// shared by the radius filter cells and its top level
// depends on nothing
`default_nettype none

package gdrf_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 24;
  localparam int CORDIC_ITER_MAX       = 40;

  localparam int COORD_W   = 32;  // coordinates, radius and config data
  localparam int DEG_W     = 33;  // degrees q24 after subtraction or doubling
  localparam int ANG_W     = 34;  // radians q30 and cordic datapath
  localparam int A_W       = 31;  // haversine term, 0 to 1.0 in q30
  localparam int SQRT_IN_W = 61;  // haversine term shifted up by 30
  localparam int SQRT_W    = 31;  // root of a 61 bit value
  localparam int D16_W     = 29;  // spherical distance in 1/16 m
  localparam int DIST_SQ_W = 60;

  localparam logic [28:0] DEG2RAD_K = 29'd299845282;  // floor(pi/180 * 2^34)

  localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 34'sd6746518852;
  localparam logic [A_W-1:0]          Q30_ONE     = 31'h4000_0000;

  // 2 * earth radius * 512, split for two narrow multipliers
  localparam logic [32:0] DIST_K = 33'd6525744702;
  localparam int DIST_LO_W = 17;

  localparam logic [DIST_SQ_W-1:0] DIST_SQ_MAX = {DIST_SQ_W{1'b1}};

  typedef enum logic [1:0] {
    REG_COORD_MODE = 2'd0,
    REG_CENTER_X   = 2'd1,
    REG_CENTER_Y   = 2'd2,
    REG_RADIUS     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] x;
    logic signed [ANG_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [SQRT_IN_W-1:0] rem;
    logic [SQRT_W-1:0]    root;
  } sqrt_t;

  typedef struct packed {
    logic                mode;
    logic [COORD_W-1:0]  ax;
    logic [COORD_W-1:0]  ay;
    logic [3:0]          neg;
  } side_t;

  // atan(2^-i) in q30, rounded
  localparam logic [31:0] ATAN_Q30 [CORDIC_ITER_MAX] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
    32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
    32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
    32'd32,        32'd16,        32'd8,         32'd4,         32'd2,
    32'd1,         32'd1,         32'd0,         32'd0,         32'd0,
    32'd0,         32'd0,         32'd0,         32'd0,         32'd0
  };

  // reciprocal of the cordic gain in q30 for n steps, worked out at elaboration
  function automatic logic [ANG_W-1:0] cordic_gain(input int n);
    logic [63:0] a2;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    logic [63:0] num;
    logic [63:0] q;
    a2 = 64'd1 << 60;
    for (int i = 0; i < CORDIC_ITER_MAX; i++) begin
      if (i < n) begin
        a2 = a2 + (a2 >> (2 * i));
      end
    end
    v    = a2;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    num = 64'd1 << 60;
    q   = '0;
    rem = '0;
    for (int b = 60; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= res) begin
        rem  = rem - res;
        q[b] = 1'b1;
      end
    end
    return q[ANG_W-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/geo_distance_radius_filter.sv
// geo_distance_radius_filter: radius test of streamed points, haversine or planar
// depends on gdrf_pkg, gdrf_rot_cell, gdrf_sqrt_cell, gdrf_vec_cell
//
//  channel  signals                                   direction
//  config   cfg_we, cfg_idx, cfg_data                 in, write only
//  points   in_valid, in_stall, point_x, point_y      in
//  results  out_valid, out_stall, in_radius, dist_sq  out
//
// one point per cycle while no result is stalled; the depth is set by the row of
// rotation cells, the two rows of 31 square root cells and the row of vectoring cells
// reset clears the config registers and every stage valid bit
// a stalled result freezes the whole row of cells; any other cycle takes a point
`default_nettype none

module geo_distance_radius_filter #(
  parameter int CORDIC_ITERATIONS = gdrf_pkg::CORDIC_ITERATIONS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_idx,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    in_radius,
  output logic [59:0]             dist_sq
);

  localparam int N       = CORDIC_ITERATIONS;
  localparam int AW      = gdrf_pkg::ANG_W;
  localparam int DW      = gdrf_pkg::DEG_W;
  localparam int ST_M1   = N + 3;
  localparam int ST_SQ0  = N + 5;
  localparam int ST_VEC0 = ST_SQ0 + gdrf_pkg::SQRT_W;
  localparam int ST_D1   = ST_VEC0 + N;
  localparam int DEPTH   = ST_D1 + 3;

  localparam logic signed [AW-1:0] GAIN = signed'(gdrf_pkg::cordic_gain(N));

  logic              coord_mode;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic [31:0]       radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_mode <= 1'b0;
      center_x   <= '0;
      center_y   <= '0;
      radius     <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        gdrf_pkg::REG_COORD_MODE: coord_mode <= cfg_data[0];
        gdrf_pkg::REG_CENTER_X:   center_x   <= signed'(cfg_data);
        gdrf_pkg::REG_CENTER_Y:   center_y   <= signed'(cfg_data);
        gdrf_pkg::REG_RADIUS:     radius     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic             en;
  logic [DEPTH-1:0] vld;

  assign en        = !(vld[DEPTH-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  gdrf_pkg::side_t sd [ST_D1];

  // stage 0: differences in degrees q24, and planar magnitudes
  logic signed [DW-1:0] dlat;
  logic signed [DW-1:0] dlon;
  logic signed [DW-1:0] dv [4];

  assign dlat = signed'({point_y[31], point_y}) - signed'({center_y[31], center_y});
  assign dlon = signed'({point_x[31], point_x}) - signed'({center_x[31], center_x});

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0]    <= dlat;
      dv[1]    <= dlon;
      dv[2]    <= signed'({center_y, 1'b0});
      dv[3]    <= signed'({point_y, 1'b0});
      sd[0].mode <= coord_mode;
      sd[0].ax   <= dlon[DW-1] ? 32'(-dlon) : dlon[31:0];
      sd[0].ay   <= dlat[DW-1] ? 32'(-dlat) : dlat[31:0];
      sd[0].neg  <= '0;
    end
  end

  // stage 1: to radians, stage 2: range reduction and fold
  logic signed [AW-1:0]     th [4];
  logic signed [DW+29:0]    rad_prod [4];
  logic signed [AW-1:0]     t1 [4];
  logic signed [AW-1:0]     zf [4];
  logic                     fneg [4];
  logic signed [AW-1:0]     z0 [4];
  gdrf_pkg::cordic_t        rot [4][N+1];

  for (genvar c = 0; c < 4; c++) begin : g_front
    assign rad_prod[c] = dv[c] * signed'({1'b0, gdrf_pkg::DEG2RAD_K});

    always_comb begin
      if (th[c] > gdrf_pkg::PI_Q30) begin
        t1[c] = th[c] - gdrf_pkg::TWO_PI_Q30;
      end else if (th[c] < -gdrf_pkg::PI_Q30) begin
        t1[c] = th[c] + gdrf_pkg::TWO_PI_Q30;
      end else begin
        t1[c] = th[c];
      end
      if (t1[c] > gdrf_pkg::HALF_PI_Q30) begin
        zf[c]   = t1[c] - gdrf_pkg::PI_Q30;
        fneg[c] = 1'b1;
      end else if (t1[c] < -gdrf_pkg::HALF_PI_Q30) begin
        zf[c]   = t1[c] + gdrf_pkg::PI_Q30;
        fneg[c] = 1'b1;
      end else begin
        zf[c]   = t1[c];
        fneg[c] = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        th[c] <= AW'(rad_prod[c] >>> 28);
        z0[c] <= zf[c];
      end
    end

    assign rot[c][0] = '{x: GAIN, y: '0, z: z0[c]};

    for (genvar j = 0; j < N; j++) begin : g_rot
      gdrf_rot_cell #(.SHIFT(j)) u_rot (
        .clk   (clk),
        .en    (en),
        .d_in  (rot[c][j]),
        .d_out (rot[c][j+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[1]      <= sd[0];
      sd[2].mode <= sd[1].mode;
      sd[2].ax   <= sd[1].ax;
      sd[2].ay   <= sd[1].ay;
      sd[2].neg  <= {fneg[3], fneg[2], fneg[1], fneg[0]};
    end
  end

  for (genvar i = 3; i < ST_D1; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  // haversine term: squares of the half-angle sines and product of cosines
  logic signed [AW-1:0] cos1;
  logic signed [AW-1:0] cos2;
  logic signed [67:0]   p_s1;
  logic signed [67:0]   p_s2;
  logic signed [67:0]   p_cc;
  logic signed [AW-1:0] s1sq;
  logic signed [AW-1:0] s2sq;
  logic signed [AW-1:0] tcos;
  logic signed [67:0]   p_t;
  logic signed [35:0]   a_sum;
  logic [gdrf_pkg::A_W-1:0] a_q30;

  assign cos1 = sd[ST_M1-1].neg[2] ? -rot[2][N].x : rot[2][N].x;
  assign cos2 = sd[ST_M1-1].neg[3] ? -rot[3][N].x : rot[3][N].x;
  assign p_s1 = rot[0][N].y * rot[0][N].y;
  assign p_s2 = rot[1][N].y * rot[1][N].y;
  assign p_cc = cos1 * cos2;
  assign p_t  = tcos * s2sq;
  assign a_sum = 36'(s1sq) + 36'(p_t >>> 30);

  always_ff @(posedge clk) begin
    if (en) begin
      s1sq <= AW'(p_s1 >>> 30);
      s2sq <= AW'(p_s2 >>> 30);
      tcos <= AW'(p_cc >>> 30);
      if (a_sum[35]) begin
        a_q30 <= '0;
      end else if (a_sum > 36'(gdrf_pkg::Q30_ONE)) begin
        a_q30 <= gdrf_pkg::Q30_ONE;
      end else begin
        a_q30 <= a_sum[gdrf_pkg::A_W-1:0];
      end
    end
  end

  // square roots of a and 1-a, one root bit per cell
  gdrf_pkg::sqrt_t sq_h [gdrf_pkg::SQRT_W+1];
  gdrf_pkg::sqrt_t sq_c [gdrf_pkg::SQRT_W+1];

  assign sq_h[0] = '{rem: {a_q30, 30'b0}, root: '0};
  assign sq_c[0] = '{rem: {gdrf_pkg::Q30_ONE - a_q30, 30'b0}, root: '0};

  for (genvar j = 0; j < gdrf_pkg::SQRT_W; j++) begin : g_sqrt
    gdrf_sqrt_cell #(.BITPOS(gdrf_pkg::SQRT_W - 1 - j)) u_sq_h (
      .clk   (clk),
      .en    (en),
      .d_in  (sq_h[j]),
      .d_out (sq_h[j+1])
    );
    gdrf_sqrt_cell #(.BITPOS(gdrf_pkg::SQRT_W - 1 - j)) u_sq_c (
      .clk   (clk),
      .en    (en),
      .d_in  (sq_c[j]),
      .d_out (sq_c[j+1])
    );
  end

  // atan2 of the two roots
  gdrf_pkg::cordic_t vec [N+1];

  assign vec[0] = '{x: signed'({3'b000, sq_c[gdrf_pkg::SQRT_W].root}),
                    y: signed'({3'b000, sq_h[gdrf_pkg::SQRT_W].root}),
                    z: '0};

  for (genvar j = 0; j < N; j++) begin : g_vec
    gdrf_vec_cell #(.SHIFT(j)) u_vec (
      .clk   (clk),
      .en    (en),
      .d_in  (vec[j]),
      .d_out (vec[j+1])
    );
  end

  // distance scaling and planar squares, then compare and output register
  logic [30:0]  ang;
  logic [47:0]  p_lo;
  logic [46:0]  p_hi;
  logic [63:0]  xx;
  logic [63:0]  yy;
  logic [63:0]  rr;
  logic         mode_d1;
  logic [63:0]  d_prod;
  logic [63:0]  d_rnd;
  logic [64:0]  dd;
  logic [gdrf_pkg::D16_W-1:0] d16;
  logic [63:0]  dd_d2;
  logic         in_p;
  logic         mode_d2;
  logic [57:0]  dsq_s;
  logic         in_s;
  logic [59:0]  dsq_p;
  logic         hit;

  assign ang = vec[N].z[AW-1] ? '0 : vec[N].z[30:0];

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo    <= ang * gdrf_pkg::DIST_K[gdrf_pkg::DIST_LO_W-1:0];
      p_hi    <= ang * gdrf_pkg::DIST_K[32:gdrf_pkg::DIST_LO_W];
      xx      <= sd[ST_D1-1].ax * sd[ST_D1-1].ax;
      yy      <= sd[ST_D1-1].ay * sd[ST_D1-1].ay;
      rr      <= radius * radius;
      mode_d1 <= sd[ST_D1-1].mode;
    end
  end

  assign d_prod = (64'(p_hi) << gdrf_pkg::DIST_LO_W) + 64'(p_lo);
  assign d_rnd  = d_prod + (64'd1 << 34);
  assign dd     = {1'b0, xx} + {1'b0, yy};

  always_ff @(posedge clk) begin
    if (en) begin
      d16     <= d_rnd[63:35];
      dd_d2   <= dd[63:0];
      in_p    <= !dd[64] && (dd[63:0] <= rr);
      mode_d2 <= mode_d1;
    end
  end

  assign dsq_s  = d16 * d16;
  assign in_s   = {3'b000, d16} <= radius;
  assign dsq_p  = (dd_d2 > 64'(gdrf_pkg::DIST_SQ_MAX)) ? gdrf_pkg::DIST_SQ_MAX : dd_d2[59:0];
  assign hit    = mode_d2 ? in_p : in_s;

  always_ff @(posedge clk) begin
    if (en) begin
      in_radius <= hit;
      if (!hit) begin
        dist_sq <= '0;
      end else if (mode_d2) begin
        dist_sq <= dsq_p;
      end else begin
        dist_sq <= {2'b00, dsq_s};
      end
    end
  end

endmodule

`default_nettype wire

### sv/gdrf_rot_cell.sv
// gdrf_rot_cell: one cordic rotation step with its output register
// depends on gdrf_pkg
`default_nettype none

module gdrf_rot_cell #(
  parameter int SHIFT = 0
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire gdrf_pkg::cordic_t d_in,
  output gdrf_pkg::cordic_t      d_out
);

  localparam logic signed [gdrf_pkg::ANG_W-1:0] ATAN =
    signed'({2'b00, gdrf_pkg::ATAN_Q30[SHIFT]});

  logic signed [gdrf_pkg::ANG_W-1:0] dx;
  logic signed [gdrf_pkg::ANG_W-1:0] dy;
  gdrf_pkg::cordic_t                 d_next;

  always_comb begin
    dx = d_in.y >>> SHIFT;
    dy = d_in.x >>> SHIFT;
    if (!d_in.z[gdrf_pkg::ANG_W-1]) begin
      d_next.x = d_in.x - dx;
      d_next.y = d_in.y + dy;
      d_next.z = d_in.z - ATAN;
    end else begin
      d_next.x = d_in.x + dx;
      d_next.y = d_in.y - dy;
      d_next.z = d_in.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

`default_nettype wire

### sv/gdrf_vec_cell.sv
// gdrf_vec_cell: one cordic vectoring step with its output register
// depends on gdrf_pkg
`default_nettype none

module gdrf_vec_cell #(
  parameter int SHIFT = 0
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire gdrf_pkg::cordic_t d_in,
  output gdrf_pkg::cordic_t      d_out
);

  localparam logic signed [gdrf_pkg::ANG_W-1:0] ATAN =
    signed'({2'b00, gdrf_pkg::ATAN_Q30[SHIFT]});

  logic signed [gdrf_pkg::ANG_W-1:0] dx;
  logic signed [gdrf_pkg::ANG_W-1:0] dy;
  gdrf_pkg::cordic_t                 d_next;

  always_comb begin
    dx = d_in.y >>> SHIFT;
    dy = d_in.x >>> SHIFT;
    // drive y towards zero, angle builds up in z
    if (!d_in.y[gdrf_pkg::ANG_W-1]) begin
      d_next.x = d_in.x + dx;
      d_next.y = d_in.y - dy;
      d_next.z = d_in.z + ATAN;
    end else begin
      d_next.x = d_in.x - dx;
      d_next.y = d_in.y + dy;
      d_next.z = d_in.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

`default_nettype wire

### sv/gdrf_sqrt_cell.sv
// gdrf_sqrt_cell: one bit of a restoring integer square root, registered
// depends on gdrf_pkg
`default_nettype none

module gdrf_sqrt_cell #(
  parameter int BITPOS = 0
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire gdrf_pkg::sqrt_t d_in,
  output gdrf_pkg::sqrt_t      d_out
);

  localparam int TW = gdrf_pkg::SQRT_IN_W + 1;

  logic [TW-1:0]   trial;
  gdrf_pkg::sqrt_t d_next;

  always_comb begin
    // (root + 2^k)^2 - root^2
    trial = ({{(TW - gdrf_pkg::SQRT_W){1'b0}}, d_in.root} << (BITPOS + 1))
          + ({{(TW - 1){1'b0}}, 1'b1} << (2 * BITPOS));
    d_next = d_in;
    if ({1'b0, d_in.rem} >= trial) begin
      d_next.rem  = d_in.rem - trial[gdrf_pkg::SQRT_IN_W-1:0];
      d_next.root = d_in.root | (gdrf_pkg::SQRT_W'(1) << BITPOS);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

`default_nettype wire

### sv/gdrf_checker.sv
// gdrf_checker: port-level assertions for the radius filter, bound to its top level
// depends on geo_distance_radius_filter
`default_nettype none

module gdrf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        in_radius,
  input wire logic [59:0] dist_sq
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(dist_sq) && $stable(in_radius))
    else $error("result changed while stalled");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_radius |-> dist_sq == 60'd0)
    else $error("outside point with non-zero distance");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // the row only stops for a stalled result
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

endmodule

bind geo_distance_radius_filter gdrf_checker u_gdrf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .in_radius (in_radius),
  .dist_sq   (dist_sq)
);

`default_nettype wire
